@@ rtl/dssc_pkg.sv @@
// Package: types, constants and CRC helpers for the disk sector scramble/CRC codec.
package dssc_pkg;

    localparam int unsigned POS_W      = 9;
    localparam logic [7:0]  SCRAMBLE_KEY = 8'hB3;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [POS_W-1:0] HEADER_LEN    = 9'd4;
    localparam logic [POS_W-1:0] CRC_LEN       = 9'd2;
    localparam logic [POS_W-1:0] DATA_LEN_FULL = 9'd256;
    localparam logic [POS_W-1:0] DATA_LEN_HALF = 9'd128;
    localparam logic [1:0]  FMT_HALF   = 2'd2;
    localparam logic [1:0]  FMT_RESET  = 2'd1;

    // result queue
    localparam int unsigned MAX_RES  = 4;
    localparam int unsigned Q_DEPTH  = 8;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

    typedef enum logic {
        CMD_DECODE = 1'b0,
        CMD_ENCODE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_CRC    = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_BUSY      = 2'd0,
        ST_OK        = 2'd1,
        ST_CRC_BAD   = 2'd2,
        ST_PROTECTED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      byte_kind;
        t_status    sector_status;
        logic       last_of_sector;
    } t_result;

    // reflected CRC-16 (poly 0x8408) nibble table
    function automatic logic [15:0] crc_nib_tab(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'h0: v = 16'h0000;
            4'h1: v = 16'h1081;
            4'h2: v = 16'h2102;
            4'h3: v = 16'h3183;
            4'h4: v = 16'h4204;
            4'h5: v = 16'h5285;
            4'h6: v = 16'h6306;
            4'h7: v = 16'h7387;
            4'h8: v = 16'h8408;
            4'h9: v = 16'h9489;
            4'hA: v = 16'hA50A;
            4'hB: v = 16'hB58B;
            4'hC: v = 16'hC60C;
            4'hD: v = 16'hD68D;
            4'hE: v = 16'hE70E;
            4'hF: v = 16'hF78F;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // low nibble first, then high nibble
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c1;
        logic [15:0] c2;
        c1 = {4'h0, crc[15:4]} ^ crc_nib_tab(crc[3:0] ^ b[3:0]);
        c2 = {4'h0, c1[15:4]} ^ crc_nib_tab(c1[3:0] ^ b[7:4]);
        return c2;
    endfunction

endpackage

@@ rtl/disk_sector_scramble_crc_codec.sv @@
// Top level: byte-serial sector codec with scrambling and nibble-table CRC-16.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------------
//  input    | i_valid / o_ready    | i_command, i_data_byte, i_first_of_sector
//  result   | o_valid / i_ready    | o_out_byte, o_byte_kind, o_sector_status,
//           |                      | o_last_of_sector
//  config   | i_cfg_we             | i_cfg_wdata (sector_format)
//
// One item is taken per cycle while o_ready is high. Its results (0 to 4) are worked out
// in the same cycle and pushed into an 8-entry result queue; the queue drains one
// result per cycle while i_ready is high. o_ready is high while the queue has room for
// four results, so items that give at most one result stream at one per cycle; a
// stalled output holds off input once more than four results wait. Reset (synchronous,
// active low) empties the queue and restores format 1, position 0 and CRC 0xFFFF.
module disk_sector_scramble_crc_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_sector,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_byte_kind,
    output logic [1:0]  o_sector_status,
    output logic        o_last_of_sector,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);
    import dssc_pkg::*;

    // sector state
    logic [1:0]        r_fmt;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [15:0]       r_crc,     n_crc;
    logic              r_discard, n_discard;
    logic [7:0]        r_crc_hi,  n_crc_hi;
    logic [7:0]        r_hdr [4];
    logic              w_hdr_we;

    // result queue
    t_result               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_wr_ptr;
    logic [Q_PTR_W-1:0]    r_rd_ptr;
    logic [Q_CNT_W-1:0]    r_count;

    t_result               w_res [MAX_RES];
    logic [RES_CNT_W-1:0]  w_nres;

    logic                  w_acc;
    logic                  w_pop;
    logic [POS_W-1:0]      w_pos;
    logic [15:0]           w_crc;
    logic                  w_discard;
    logic [POS_W-1:0]      w_data_end;
    logic [POS_W-1:0]      w_done;
    logic [7:0]            w_clear;
    logic [15:0]           w_crc_upd;
    t_command              w_cmd;
    t_result               w_head;

    assign o_ready = (r_count <= Q_CNT_W'(Q_DEPTH - MAX_RES));
    assign w_acc   = i_valid && o_ready;
    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;

    assign w_head           = r_q[r_rd_ptr];
    assign o_out_byte       = w_head.out_byte;
    assign o_byte_kind      = w_head.byte_kind;
    assign o_sector_status  = w_head.sector_status;
    assign o_last_of_sector = w_head.last_of_sector;

    // a new sector clears position and discard and reloads the CRC init value before the byte is used
    assign w_pos      = i_first_of_sector ? '0 : r_pos;
    assign w_crc      = i_first_of_sector ? CRC_INIT : r_crc;
    assign w_discard  = i_first_of_sector ? 1'b0 : r_discard;
    assign w_data_end = HEADER_LEN + ((r_fmt == FMT_HALF) ? DATA_LEN_HALF : DATA_LEN_FULL);
    assign w_done     = w_data_end + CRC_LEN;
    assign w_cmd      = t_command'(i_command);

    // CRC always runs over clear bytes: header as is, data descrambled on decode
    assign w_clear    = ((w_pos < HEADER_LEN) || (w_cmd == CMD_ENCODE))
                        ? i_data_byte : (i_data_byte ^ SCRAMBLE_KEY);
    assign w_crc_upd  = crc_byte(w_crc, w_clear);

    always_comb begin
        n_pos     = w_pos;
        n_crc     = w_crc;
        n_discard = w_discard;
        n_crc_hi  = r_crc_hi;
        w_hdr_we  = 1'b0;
        w_nres    = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            w_res[k] = '{out_byte: 8'h00, byte_kind: KIND_STATUS,
                         sector_status: ST_BUSY, last_of_sector: 1'b0};
        end

        priority if (w_discard || (w_pos >= w_done)) begin
            // dead bytes: nothing
        end else if (w_pos < HEADER_LEN) begin
            w_hdr_we = 1'b1;
            n_crc    = w_crc_upd;
            n_pos    = w_pos + 1'b1;
            if (w_cmd == CMD_DECODE) begin
                w_res[0] = '{out_byte: i_data_byte, byte_kind: KIND_HEADER,
                             sector_status: ST_BUSY, last_of_sector: 1'b0};
                w_nres   = RES_CNT_W'(1);
            end else if (w_pos == HEADER_LEN - 1'b1) begin
                if (r_hdr[1] != 8'h00) begin
                    n_discard = 1'b1;
                    w_res[0]  = '{out_byte: 8'h00, byte_kind: KIND_STATUS,
                                  sector_status: ST_PROTECTED, last_of_sector: 1'b1};
                    w_nres    = RES_CNT_W'(1);
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        w_res[k] = '{out_byte: r_hdr[k], byte_kind: KIND_HEADER,
                                     sector_status: ST_BUSY, last_of_sector: 1'b0};
                    end
                    w_res[3] = '{out_byte: i_data_byte, byte_kind: KIND_HEADER,
                                 sector_status: ST_BUSY, last_of_sector: 1'b0};
                    w_nres   = RES_CNT_W'(4);
                end
            end
        end else if (w_pos < w_data_end) begin
            n_crc = w_crc_upd;
            n_pos = w_pos + 1'b1;
            if (w_cmd == CMD_DECODE) begin
                w_res[0] = '{out_byte: w_clear, byte_kind: KIND_DATA,
                             sector_status: ST_BUSY, last_of_sector: 1'b0};
                w_nres   = RES_CNT_W'(1);
            end else begin
                w_res[0] = '{out_byte: i_data_byte ^ SCRAMBLE_KEY, byte_kind: KIND_DATA,
                             sector_status: ST_BUSY, last_of_sector: 1'b0};
                w_nres   = RES_CNT_W'(1);
                if (w_pos == w_data_end - 1'b1) begin
                    // trailing CRC, high byte first
                    w_res[1] = '{out_byte: w_crc_upd[15:8], byte_kind: KIND_CRC,
                                 sector_status: ST_BUSY, last_of_sector: 1'b0};
                    w_res[2] = '{out_byte: w_crc_upd[7:0], byte_kind: KIND_CRC,
                                 sector_status: ST_OK, last_of_sector: 1'b1};
                    w_nres   = RES_CNT_W'(3);
                    n_pos    = w_done;
                end
            end
        end else if (w_cmd == CMD_ENCODE) begin
            // encode at a CRC position: ignored
        end else if (w_pos == w_data_end) begin
            n_crc_hi = i_data_byte;
            n_pos    = w_pos + 1'b1;
        end else begin
            w_res[0] = '{out_byte: 8'h00, byte_kind: KIND_STATUS,
                         sector_status: ({r_crc_hi, i_data_byte} == w_crc) ? ST_OK : ST_CRC_BAD,
                         last_of_sector: 1'b1};
            w_nres   = RES_CNT_W'(1);
            n_pos    = w_done;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_RESET;
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_discard <= 1'b0;
            r_crc_hi  <= 8'h00;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_pos     <= n_pos;
                r_crc     <= n_crc;
                r_discard <= n_discard;
                r_crc_hi  <= n_crc_hi;
                r_wr_ptr  <= r_wr_ptr + Q_PTR_W'(w_nres);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (w_acc ? Q_CNT_W'(w_nres) : '0) - Q_CNT_W'(w_pop);
        end
    end

    // payload storage: header bytes and queued results
    always_ff @(posedge i_clk) begin
        if (w_acc && w_hdr_we) begin
            r_hdr[w_pos[1:0]] <= i_data_byte;
        end
        if (w_acc) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (RES_CNT_W'(k) < w_nres) begin
                    r_q[r_wr_ptr + Q_PTR_W'(k)] <= w_res[k];
                end
            end
        end
    end

    // checks
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_last_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_sector) |-> (o_sector_status != ST_BUSY))
        else $error("final result without status");

    a_mid_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_sector) |-> (o_sector_status == ST_BUSY))
        else $error("status on a non-final result");

    a_discard_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_pos == HEADER_LEN))
        else $error("discarded sector moved past header");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= HEADER_LEN + DATA_LEN_FULL + CRC_LEN)
        else $error("byte position out of range");

endmodule
